// ===== design/rau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and types for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int FIELD_W   = 32;

    typedef enum logic [2:0] {
        K_REDUCE  = 3'd0,
        K_MUL     = 3'd1,
        K_DIV     = 3'd2,
        K_ADD     = 3'd3,
        K_SUB     = 3'd4,
        K_GREATER = 3'd5,
        K_LESS    = 3'd6,
        K_NONE    = 3'd7
    } t_kind;

    // Operation requested from the shared datapath unit.
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_REM = 2'd2
    } t_op;

endpackage
`default_nettype wire

// ===== design/rau_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_alu
// Shared multi-cycle unit: wrapping multiply (shift-add, one bit a cycle) and
// unsigned restoring divide giving quotient or remainder, one bit a cycle.
// ----------------------------------------------------------------------------
module rau_alu #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire rau_pkg::t_op     i_op,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_res
);
    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy, n_busy;
    logic [CW-1:0]    r_cnt, n_cnt;
    rau_pkg::t_op     r_op, n_op;
    logic [WIDTH-1:0] r_acc, n_acc;   // product or remainder
    logic [WIDTH-1:0] r_x, n_x;       // multiplicand / dividend-quotient
    logic [WIDTH-1:0] r_y, n_y;       // multiplier / divisor
    logic             r_done, n_done;

    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_shift;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_done = 1'b0;
        w_shift = {r_acc, r_x[WIDTH-1]};
        w_trial = w_shift - {1'b0, r_y};
        if (!r_busy) begin
            if (i_go) begin
                n_busy = 1'b1;
                n_cnt  = CW'(WIDTH);
                n_op   = i_op;
                n_acc  = '0;
                n_x    = i_x;
                n_y    = i_y;
            end
        end else begin
            if (r_op == rau_pkg::OP_MUL) begin
                // add shifted multiplicand where multiplier bit set
                if (r_y[0]) n_acc = r_acc + r_x;
                n_x = {r_x[WIDTH-2:0], 1'b0};
                n_y = {1'b0, r_y[WIDTH-1:1]};
            end else begin
                if (!w_trial[WIDTH]) begin
                    n_acc = w_trial[WIDTH-1:0];
                    n_x   = {r_x[WIDTH-2:0], 1'b1};
                end else begin
                    n_acc = w_shift[WIDTH-1:0];
                    n_x   = {r_x[WIDTH-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= rau_pkg::OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_done = r_done;
    assign o_res  = (r_op == rau_pkg::OP_DIV) ? r_x : r_acc;

endmodule
`default_nettype wire

// ===== design/rational_arithmetic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction reduce, multiply, divide, add, subtract and compare, sequenced over
// one shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// Sequence: multiply/divide run two unit passes; reduce runs the Euclid loop
// (up to ~1.44*WIDTH steps), then two divide passes; add/sub/compare run it on
// the denominators, then a denominator product, an lcm divide and a multiply-
// divide pair per term. A zero gcd or zero denominator ends in an error.
// One item at a time; busy drops as o_valid shows; the receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle.
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [2:0]                  i_kind,
    input  wire logic signed [rau_pkg::FIELD_W-1:0] i_a_num,
    input  wire logic signed [rau_pkg::FIELD_W-1:0] i_a_den,
    input  wire logic signed [rau_pkg::FIELD_W-1:0] i_b_num,
    input  wire logic signed [rau_pkg::FIELD_W-1:0] i_b_den,
    output logic                             o_valid,
    output logic signed [rau_pkg::FIELD_W-1:0] o_res_num,
    output logic signed [rau_pkg::FIELD_W-1:0] o_res_den,
    output logic                             o_compare_true,
    output logic                             o_div_error
);
    localparam int FW = rau_pkg::FIELD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_GCD, S_GCD_W, S_ISSUE, S_WAIT, S_FINISH
    } t_state;

    // Ordered list of unit passes; the step counter walks through it.
    typedef enum logic [2:0] {
        P_N1, P_N2, P_L, P_T1M, P_T1D, P_T2M, P_T2D
    } t_pass;

    t_state           r_state;
    t_pass            r_pass;
    rau_pkg::t_kind   r_kind;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic [WIDTH-1:0] r_ga, r_gb;       // Euclid pair
    logic [WIDTH-1:0] r_num, r_den, r_t;
    logic             r_valid, r_cmp, r_err;
    logic             r_in_gcd;
    logic [FW-1:0]    r_onum, r_oden;

    logic             w_go;
    rau_pkg::t_op     w_op;
    logic [WIDTH-1:0] w_x, w_y, w_xm, w_ym, w_q;
    logic             w_xneg, w_yneg;
    logic             w_done;
    logic [WIDTH-1:0] w_res;

    function automatic logic [WIDTH-1:0] f_in(input logic [FW-1:0] v);
        logic [WIDTH+FW-1:0] e;
        e = {{WIDTH{v[FW-1]}}, v};
        return e[WIDTH-1:0];
    endfunction

    function automatic logic [FW-1:0] f_out(input logic [WIDTH-1:0] v);
        logic [WIDTH+FW-1:0] e;
        e = {{FW{v[WIDTH-1]}}, v};
        return e[FW-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] f_mag(input logic [WIDTH-1:0] v);
        return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
    endfunction

    rau_alu #(.WIDTH(WIDTH)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_go),
        .i_op   (w_op),
        .i_x    (w_xm),
        .i_y    (w_ym),
        .o_done (w_done),
        .o_res  (w_res)
    );

    // Operand selection for the current pass (signed x, y; sign fixed after).
    always_comb begin
        w_op = rau_pkg::OP_MUL;
        w_x  = '0;
        w_y  = '0;
        if (r_state == S_GCD) begin
            w_op = rau_pkg::OP_REM;
            w_x  = r_ga;
            w_y  = r_gb;
        end else begin
            unique case (r_pass)
                P_N1: begin
                    unique case (r_kind)
                        rau_pkg::K_REDUCE: begin
                            w_op = rau_pkg::OP_DIV; w_x = r_an; w_y = r_ga;
                        end
                        rau_pkg::K_DIV: begin w_x = r_an; w_y = r_bd; end
                        default:        begin w_x = r_an; w_y = r_bn; end
                    endcase
                end
                P_N2: begin
                    unique case (r_kind)
                        rau_pkg::K_REDUCE: begin
                            w_op = rau_pkg::OP_DIV; w_x = r_ad; w_y = r_ga;
                        end
                        rau_pkg::K_DIV: begin w_x = r_ad; w_y = r_bn; end
                        rau_pkg::K_MUL: begin w_x = r_ad; w_y = r_bd; end
                        default:        begin w_x = r_ad; w_y = r_bd; end
                    endcase
                end
                P_L:   begin w_op = rau_pkg::OP_DIV; w_x = r_t;  w_y = r_ga; end
                P_T1M: begin w_x = r_an; w_y = r_den; end
                P_T1D: begin w_op = rau_pkg::OP_DIV; w_x = r_t;  w_y = r_ad; end
                P_T2M: begin w_x = r_bn; w_y = r_den; end
                P_T2D: begin w_op = rau_pkg::OP_DIV; w_x = r_t;  w_y = r_bd; end
                default: ;
            endcase
        end
        if (w_op == rau_pkg::OP_MUL) begin
            w_xm = w_x;
            w_ym = w_y;
            w_xneg = 1'b0;
            w_yneg = 1'b0;
        end else begin
            w_xneg = (r_state != S_GCD) && w_x[WIDTH-1];
            w_yneg = (r_state != S_GCD) && (r_pass == P_T1D || r_pass == P_T2D)
                     && w_y[WIDTH-1];
            w_xm = (r_state == S_GCD) ? w_x : f_mag(w_x);
            w_ym = w_yneg ? f_mag(w_y) : w_y;
        end
    end

    assign w_go = (r_state == S_GCD) || (r_state == S_ISSUE);
    // Quotient sign fix, held stable through the pass since operands hold.
    assign w_q  = (w_xneg != w_yneg) ? (~w_res + WIDTH'(1)) : w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_in_gcd <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind <= rau_pkg::t_kind'(i_kind);
                        r_an <= f_in(i_a_num);
                        r_ad <= f_in(i_a_den);
                        r_bn <= f_in(i_b_num);
                        r_bd <= f_in(i_b_den);
                        r_num <= '0;
                        r_den <= '0;
                        r_cmp <= 1'b0;
                        r_err <= 1'b0;
                        r_pass <= P_N1;
                        unique case (rau_pkg::t_kind'(i_kind))
                            rau_pkg::K_REDUCE: begin
                                r_ga <= f_mag(f_in(i_a_num));
                                r_gb <= f_mag(f_in(i_a_den));
                                r_state <= S_GCD_W;
                            end
                            rau_pkg::K_MUL, rau_pkg::K_DIV: r_state <= S_ISSUE;
                            rau_pkg::K_NONE: r_state <= S_FINISH;
                            default: begin
                                r_ga <= f_mag(f_in(i_a_den));
                                r_gb <= f_mag(f_in(i_b_den));
                                r_pass <= P_N2;
                                r_state <= S_GCD_W;
                            end
                        endcase
                    end
                end
                S_GCD_W: begin
                    // test for end of Euclid loop
                    if (r_gb == '0) begin
                        if (r_ga == '0 || (r_kind != rau_pkg::K_REDUCE
                                && (r_ad == '0 || r_bd == '0))) begin
                            r_err <= 1'b1;
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_ISSUE;
                        end
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    r_in_gcd <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        if (r_in_gcd) begin
                            // Euclid step: (a, b) <- (b, a mod b)
                            r_ga <= r_gb;
                            r_gb <= w_res;
                            r_in_gcd <= 1'b0;
                            r_state <= S_GCD_W;
                        end else begin
                            r_state <= S_ISSUE;
                            unique case (r_pass)
                                P_N1: begin
                                    r_num <= (w_op == rau_pkg::OP_MUL) ? w_res : w_q;
                                    r_pass <= P_N2;
                                end
                                P_N2: begin
                                    if (r_kind == rau_pkg::K_REDUCE
                                            || r_kind == rau_pkg::K_MUL
                                            || r_kind == rau_pkg::K_DIV) begin
                                        r_den <= (w_op == rau_pkg::OP_MUL) ? w_res : w_q;
                                        r_state <= S_FINISH;
                                    end else begin
                                        r_t <= w_res;
                                        r_pass <= P_L;
                                    end
                                end
                                P_L:   begin r_den <= w_q; r_pass <= P_T1M; end
                                P_T1M: begin r_t <= w_res; r_pass <= P_T1D; end
                                P_T1D: begin r_num <= w_q; r_pass <= P_T2M; end
                                P_T2M: begin r_t <= w_res; r_pass <= P_T2D; end
                                P_T2D: begin
                                    r_num <= (r_kind == rau_pkg::K_ADD)
                                             ? r_num + w_q : r_num - w_q;
                                    r_state <= S_FINISH;
                                end
                                default: r_state <= S_FINISH;
                            endcase
                        end
                    end
                end
                S_FINISH: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_err) begin
                        r_onum <= '0;
                        r_oden <= '0;
                        r_cmp <= 1'b0;
                    end else if (r_kind == rau_pkg::K_GREATER) begin
                        r_cmp <= (r_num != '0) && !r_num[WIDTH-1];
                        r_onum <= '0;
                        r_oden <= '0;
                    end else if (r_kind == rau_pkg::K_LESS) begin
                        r_cmp <= r_num[WIDTH-1];
                        r_onum <= '0;
                        r_oden <= '0;
                    end else begin
                        r_onum <= f_out(r_num);
                        r_oden <= f_out(r_den);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_res_num      = r_onum;
    assign o_res_den      = r_oden;
    assign o_compare_true = r_cmp;
    assign o_div_error    = r_err;

endmodule
`default_nettype wire

// ===== design/rau_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [31:0] o_res_num,
    input wire logic [31:0] o_res_den,
    input wire logic        o_compare_true,
    input wire logic        o_div_error
);
    // a result word closes the job: never two in a row
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("back-to-back result words");

    // a word appears only as the job ends
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy)) else $error("result without a job");

    // an accepted job raises busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");

    // an error word carries zero fields
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_error) |-> (o_res_num == '0 && o_res_den == '0
                                      && !o_compare_true))
        else $error("error word with data");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_res_num     (o_res_num),
    .o_res_den     (o_res_den),
    .o_compare_true(o_compare_true),
    .o_div_error   (o_div_error)
);
`default_nettype wire

// ===== dv/rational_arithmetic_unit_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Drives fraction words into the unit, predicts each result from an
// independent model of the arithmetic and checks every result word in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        cmp;
        logic        err;
    } t_frac_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_kind;
    logic [31:0] i_a_num, i_a_den, i_b_num, i_b_den;
    logic        o_valid;
    logic [31:0] o_res_num, o_res_den;
    logic        o_compare_true, o_div_error;

    t_frac_res   frac_expected_q[$];
    int          fail_cnt;
    bit          idle_en;

    rational_arithmetic_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_a_num        (i_a_num),
        .i_a_den        (i_a_den),
        .i_b_num        (i_b_num),
        .i_b_den        (i_b_den),
        .o_valid        (o_valid),
        .o_res_num      (o_res_num),
        .o_res_den      (o_res_den),
        .o_compare_true (o_compare_true),
        .o_div_error    (o_div_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] mag32(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic logic [31:0] euclid_gcd(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // truncating signed divide by a magnitude with a separate sign
    function automatic logic [31:0] trunc_div(logic [31:0] x, logic [31:0] dmag,
                                              logic dneg);
        logic [31:0] q;
        q = mag32(x) / dmag;
        return (x[31] != dneg) ? -q : q;
    endfunction

    // common-denominator sum or difference; returns 0 on zero denominator
    function automatic logic frac_add_sub(logic [31:0] an, logic [31:0] ad,
                                          logic [31:0] bn, logic [31:0] bd,
                                          logic sub, output logic [31:0] num,
                                          output logic [31:0] den);
        logic [31:0] g, l, t1, t2;
        num = '0;
        den = '0;
        g = euclid_gcd(mag32(ad), mag32(bd));
        if (g == 0 || ad == 0 || bd == 0) return 1'b0;
        l = trunc_div(ad * bd, g, 1'b0);
        t1 = trunc_div(an * l, mag32(ad), ad[31]);
        t2 = trunc_div(bn * l, mag32(bd), bd[31]);
        num = sub ? t1 - t2 : t1 + t2;
        den = l;
        return 1'b1;
    endfunction

    function automatic t_frac_res frac_result(rau_pkg::t_kind k, logic [31:0] an,
                                              logic [31:0] ad, logic [31:0] bn,
                                              logic [31:0] bd);
        t_frac_res   r;
        logic [31:0] g, dn, dd;
        r = '0;
        case (k)
            rau_pkg::K_REDUCE: begin
                g = euclid_gcd(mag32(an), mag32(ad));
                if (g == 0) r.err = 1'b1;
                else begin
                    r.num = trunc_div(an, g, 1'b0);
                    r.den = trunc_div(ad, g, 1'b0);
                end
            end
            rau_pkg::K_MUL: begin
                r.num = an * bn;
                r.den = ad * bd;
            end
            rau_pkg::K_DIV: begin
                r.num = an * bd;
                r.den = ad * bn;
            end
            rau_pkg::K_ADD, rau_pkg::K_SUB: begin
                if (!frac_add_sub(an, ad, bn, bd, k == rau_pkg::K_SUB, r.num,
                                  r.den)) begin
                    r.err = 1'b1;
                    r.num = '0;
                    r.den = '0;
                end
            end
            rau_pkg::K_GREATER, rau_pkg::K_LESS: begin
                if (!frac_add_sub(an, ad, bn, bd, 1'b1, dn, dd)) r.err = 1'b1;
                else if (k == rau_pkg::K_GREATER) r.cmp = (dn != 0) && !dn[31];
                else r.cmp = dn[31];
            end
            default: ;
        endcase
        return r;
    endfunction

    // drop start for a burst of idle cycles
    task automatic idle_burst();
        if (idle_en && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    task automatic send_word(rau_pkg::t_kind k, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        idle_burst();
        start   <= 1'b1;
        i_kind  <= k;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        frac_expected_q.push_back(frac_result(k, an, ad, bn, bd));
        @(negedge i_clk);
    endtask

    // mostly small values so gcds stay nontrivial, with full-range words mixed in
    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            2: return '0;
            3: return -$urandom_range(1, 1000);
            default: return $urandom_range(1, 1000) * $urandom_range(1, 12);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_frac_res got, want;
        if (i_rst_n && o_valid) begin
            got = {o_res_num, o_res_den, o_compare_true, o_div_error};
            if (frac_expected_q.size() == 0) begin
                $display("%0t: result with none expected: %h", $time, got);
                fail_cnt++;
            end else begin
                want = frac_expected_q.pop_front();
                if (got.num !== want.num) begin
                    $display("%0t: res_num expected %h actual %h", $time, want.num, got.num);
                    fail_cnt++;
                end
                if (got.den !== want.den) begin
                    $display("%0t: res_den expected %h actual %h", $time, want.den, got.den);
                    fail_cnt++;
                end
                if (got.cmp !== want.cmp) begin
                    $display("%0t: compare_true expected %b actual %b", $time, want.cmp,
                             got.cmp);
                    fail_cnt++;
                end
                if (got.err !== want.err) begin
                    $display("%0t: div_error expected %b actual %b", $time, want.err,
                             got.err);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        send_word(rau_pkg::K_REDUCE, 32'd12, 32'd18, 32'd0, 32'd0);
        send_word(rau_pkg::K_REDUCE, 32'd0, 32'd0, 32'hffff_ffff, 32'hffff_ffff);
        send_word(rau_pkg::K_REDUCE, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_word(rau_pkg::K_REDUCE, 32'h8000_0000, 32'hffff_fffa, 32'd0, 32'd0);
        send_word(rau_pkg::K_REDUCE, 32'h7fff_ffff, 32'h0, 32'd0, 32'd0);
        send_word(rau_pkg::K_MUL, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff, 32'd3);
        send_word(rau_pkg::K_MUL, 32'hffff_fffe, 32'd5, 32'd3, 32'hffff_fff9);
        send_word(rau_pkg::K_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
        send_word(rau_pkg::K_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'h8000_0000);
        send_word(rau_pkg::K_ADD, 32'd1, 32'd6, 32'd1, 32'd4);
        send_word(rau_pkg::K_ADD, 32'd1, 32'd0, 32'd1, 32'd4);
        send_word(rau_pkg::K_ADD, 32'd1, 32'd0, 32'd1, 32'd0);
        send_word(rau_pkg::K_SUB, 32'd1, 32'd3, 32'd1, 32'hffff_fffa);
        send_word(rau_pkg::K_SUB, 32'd2, 32'd3, 32'd1, 32'd0);
        send_word(rau_pkg::K_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000);
        send_word(rau_pkg::K_GREATER, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(rau_pkg::K_GREATER, 32'd1, 32'd2, 32'd2, 32'd4);
        send_word(rau_pkg::K_GREATER, 32'd1, 32'd2, 32'd1, 32'd0);
        send_word(rau_pkg::K_LESS, 32'd1, 32'd3, 32'd1, 32'd2);
        send_word(rau_pkg::K_LESS, 32'd1, 32'd2, 32'd1, 32'd2);
        send_word(rau_pkg::K_LESS, 32'd1, 32'd0, 32'd1, 32'd2);
        send_word(rau_pkg::K_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff);
    endtask

    task automatic test_random(int count);
        rau_pkg::t_kind k;
        for (int n = 0; n < count; n++) begin
            k = rau_pkg::t_kind'($urandom_range(0, 7));
            send_word(k, rand_field(), rand_field(), rand_field(), rand_field());
        end
    endtask

    initial begin
        fail_cnt = 0;
        idle_en  = 1'b1;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_kind   = rau_pkg::K_REDUCE;
        i_a_num  = '0;
        i_a_den  = '0;
        i_b_num  = '0;
        i_b_den  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(1000);
        idle_en = 1'b0;
        test_random(330);
        start <= 1'b0;
        while (frac_expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_cnt == 0 && frac_expected_q.size() == 0)
            $display("rational_arithmetic_unit test passed");
        else
            $display("rational_arithmetic_unit test failed");
        $finish;
    end

    // worst case is roughly 1350 words, each at its longest, plus idle gaps
    initial begin
        #40000000;
        $display("rational_arithmetic_unit test failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/rau_pkg.sv
design/rau_alu.sv
design/rational_arithmetic_unit.sv
design/rau_checker.sv
dv/rational_arithmetic_unit_test.sv
